[rtl/dct_ii_8_point_top_macros.svh]
`ifndef DCT_II_8_POINT_TOP_MACROS_SVH
`define DCT_II_8_POINT_TOP_MACROS_SVH

// check cons in the cycle after ante
`define DCT8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// check cons in the same cycle as ante
`define DCT8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/dct8_pkg.sv]
`timescale 1ns / 1ps
package dct8_pkg;

    localparam int SAMPLE_WIDTH   = 12;
    localparam int COEF_FRAC_BITS = 14;
    localparam int NPTS           = 8;
    localparam int HALF_PTS       = 4;
    localparam int COEF_W         = 15;
    localparam int OUT_MAX        = 16383;
    localparam int OUT_MIN        = -16384;
    localparam int DC_ANGLE       = 4;

    typedef logic signed [COEF_W-1:0] t_coef;

    // cos(m*pi/16) in Q1.31, m = 0..8
    localparam logic [31:0] COS_Q31 [9] = '{
        32'h80000000, 32'h7D8A5F40, 32'h7641AF3D, 32'h6A6D98A4, 32'h5A82799A,
        32'h471CECE7, 32'h30FBC54D, 32'h18F8B83C, 32'h00000000
    };

    // signed Q1.frac value of cos(m*pi/16), rounded to nearest
    function automatic int coef_of(input int m, input int frac);
        int          mm;
        logic        neg;
        logic [32:0] t;
        int          v;
        begin
            mm  = m & 31;
            neg = 1'b0;
            if (mm > 16) begin
                mm = 32 - mm;
            end
            if (mm > 8) begin
                mm  = 16 - mm;
                neg = 1'b1;
            end
            t = {1'b0, COS_Q31[mm[3:0]]} + (33'd1 << (30 - frac));
            t = t >> (31 - frac);
            v = int'(t[31:0]);
            return neg ? -v : v;
        end
    endfunction

endpackage

[rtl/dct8_bfly.sv]
`timescale 1ns / 1ps
module dct8_bfly #(
    parameter int SAMPLE_WIDTH = dct8_pkg::SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample [dct8_pkg::NPTS],
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH:0]   o_sum    [dct8_pkg::HALF_PTS],
    output logic signed [SAMPLE_WIDTH:0]   o_diff   [dct8_pkg::HALF_PTS]
);

    logic                         r_valid;
    logic signed [SAMPLE_WIDTH:0] r_sum  [dct8_pkg::HALF_PTS];
    logic signed [SAMPLE_WIDTH:0] r_diff [dct8_pkg::HALF_PTS];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_diff  = r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int n = 0; n < dct8_pkg::HALF_PTS; n++) begin
                r_sum[n]  <= (SAMPLE_WIDTH+1)'(i_sample[n])
                           + (SAMPLE_WIDTH+1)'(i_sample[dct8_pkg::NPTS-1-n]);
                r_diff[n] <= (SAMPLE_WIDTH+1)'(i_sample[n])
                           - (SAMPLE_WIDTH+1)'(i_sample[dct8_pkg::NPTS-1-n]);
            end
        end
    end

endmodule

[rtl/dct8_prod.sv]
`timescale 1ns / 1ps
`include "dct_ii_8_point_top_macros.svh"
module dct8_prod #(
    parameter int SAMPLE_WIDTH   = dct8_pkg::SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = dct8_pkg::COEF_FRAC_BITS,
    localparam int AW            = SAMPLE_WIDTH + COEF_FRAC_BITS + 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SAMPLE_WIDTH:0] i_sum  [dct8_pkg::HALF_PTS],
    input  logic signed [SAMPLE_WIDTH:0] i_diff [dct8_pkg::HALF_PTS],
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [AW-1:0]         o_acc  [dct8_pkg::NPTS]
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = SAMPLE_WIDTH + COEF_FRAC_BITS + 3;

    logic                 r_p_valid;
    logic                 r_s_valid;
    logic                 p_ready;
    logic                 s_ready;
    logic signed [PW-1:0] n_prod [dct8_pkg::NPTS][dct8_pkg::HALF_PTS];
    logic signed [PW-1:0] r_prod [dct8_pkg::NPTS][dct8_pkg::HALF_PTS];
    logic signed [AW-1:0] n_acc  [dct8_pkg::NPTS];
    logic signed [AW-1:0] r_acc  [dct8_pkg::NPTS];

    assign s_ready = !r_s_valid || i_ready;
    assign p_ready = !r_p_valid || s_ready;
    assign o_ready = p_ready;
    assign o_valid = r_s_valid;
    assign o_acc   = r_acc;

    for (genvar k = 0; k < dct8_pkg::NPTS; k++) begin : g_row
        for (genvar n = 0; n < dct8_pkg::HALF_PTS; n++) begin : g_col
            localparam int CI = dct8_pkg::coef_of(
                (k == 0) ? dct8_pkg::DC_ANGLE : ((2 * n + 1) * k), COEF_FRAC_BITS);
            localparam logic signed [CW-1:0] C = CW'(CI);
            if (k % 2 == 0) begin : g_even
                assign n_prod[k][n] = PW'(i_sum[n]) * PW'(C);
            end else begin : g_odd
                assign n_prod[k][n] = PW'(i_diff[n]) * PW'(C);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < dct8_pkg::NPTS; k++) begin
            n_acc[k] = AW'(r_prod[k][0]) + AW'(r_prod[k][1])
                     + AW'(r_prod[k][2]) + AW'(r_prod[k][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_valid;
            end
            if (s_ready) begin
                r_s_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && i_valid) begin
            r_prod <= n_prod;
        end
        if (s_ready && r_p_valid) begin
            r_acc <= n_acc;
        end
    end

    `DCT8_ASSERT_NEXT(a_sum_hold, i_clk, i_rst_n, r_s_valid && !i_ready, r_s_valid && $stable(r_acc[0]), "stalled sum stage changed")
    `DCT8_ASSERT_NEXT(a_prod_keep, i_clk, i_rst_n, r_p_valid && r_s_valid && !i_ready, r_p_valid, "stalled product stage dropped an item")
    `DCT8_ASSERT_NEXT(a_bubble_fill, i_clk, i_rst_n, r_p_valid && !r_s_valid, r_s_valid, "product did not advance into empty sum stage")

endmodule

[rtl/dct8_rnd.sv]
`timescale 1ns / 1ps
module dct8_rnd #(
    parameter int SAMPLE_WIDTH   = dct8_pkg::SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = dct8_pkg::COEF_FRAC_BITS,
    localparam int AW            = SAMPLE_WIDTH + COEF_FRAC_BITS + 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [AW-1:0] i_acc  [dct8_pkg::NPTS],
    output logic                 o_valid,
    input  logic                 i_ready,
    output dct8_pkg::t_coef      o_coef [dct8_pkg::NPTS]
);

    localparam int RW = AW + 1;
    localparam logic signed [RW-1:0] RND  = RW'(1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [RW-1:0] MAXV = RW'(dct8_pkg::OUT_MAX);
    localparam logic signed [RW-1:0] MINV = RW'(dct8_pkg::OUT_MIN);

    logic                 r_valid;
    logic signed [RW-1:0] n_q    [dct8_pkg::NPTS];
    dct8_pkg::t_coef      n_coef [dct8_pkg::NPTS];
    dct8_pkg::t_coef      r_coef [dct8_pkg::NPTS];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_coef  = r_coef;

    always_comb begin
        for (int k = 0; k < dct8_pkg::NPTS; k++) begin
            n_q[k] = (RW'(i_acc[k]) + RND) >>> COEF_FRAC_BITS;
            if (n_q[k] > MAXV) begin
                n_coef[k] = MAXV[dct8_pkg::COEF_W-1:0];
            end else if (n_q[k] < MINV) begin
                n_coef[k] = MINV[dct8_pkg::COEF_W-1:0];
            end else begin
                n_coef[k] = n_q[k][dct8_pkg::COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_coef <= n_coef;
        end
    end

endmodule

[rtl/dct_ii_8_point_top.sv]
`timescale 1ns / 1ps
// Eight-point DCT-II of one row of eight signed samples per item, with the DC
// term scaled by 1/sqrt2, Q1.COEF_FRAC_BITS constant coefficients and each
// coefficient rounded to nearest (ties up) and saturated to 15 bits. The
// pipeline takes one item per clock through four register stages: input
// butterfly, constant multipliers, four-term adders, then rounding into the
// output register. An accepted item passes through the butterfly, product and
// sum registers into the output register, and each stage holds its own
// valid bit and loads whenever it is empty or its successor moves, so a stall
// on the output side fills bubbles before it reaches s_axis_tready.
module dct_ii_8_point_top #(
    parameter int SAMPLE_WIDTH   = dct8_pkg::SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = dct8_pkg::COEF_FRAC_BITS,
    localparam int IN_W          = dct8_pkg::NPTS * SAMPLE_WIDTH,
    localparam int OUT_W         = dct8_pkg::NPTS * dct8_pkg::COEF_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // sample_0 .. sample_7
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // coef_0 .. coef_7
);

    localparam int AW = SAMPLE_WIDTH + COEF_FRAC_BITS + 5;

    logic signed [SAMPLE_WIDTH-1:0] sample [dct8_pkg::NPTS];
    logic signed [SAMPLE_WIDTH:0]   bf_sum  [dct8_pkg::HALF_PTS];
    logic signed [SAMPLE_WIDTH:0]   bf_diff [dct8_pkg::HALF_PTS];
    logic signed [AW-1:0]           acc     [dct8_pkg::NPTS];
    dct8_pkg::t_coef                coef    [dct8_pkg::NPTS];
    logic                           bf_valid;
    logic                           bf_ready;
    logic                           pr_valid;
    logic                           pr_ready;

    for (genvar n = 0; n < dct8_pkg::NPTS; n++) begin : g_unpack
        assign sample[n] = s_axis_tdata[n*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end

    for (genvar k = 0; k < dct8_pkg::NPTS; k++) begin : g_pack
        assign m_axis_tdata[k*dct8_pkg::COEF_W +: dct8_pkg::COEF_W] = coef[k];
    end

    dct8_bfly #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_bfly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (sample),
        .o_valid  (bf_valid),
        .i_ready  (bf_ready),
        .o_sum    (bf_sum),
        .o_diff   (bf_diff)
    );

    dct8_prod #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bf_valid),
        .o_ready (bf_ready),
        .i_sum   (bf_sum),
        .i_diff  (bf_diff),
        .o_valid (pr_valid),
        .i_ready (pr_ready),
        .o_acc   (acc)
    );

    dct8_rnd #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pr_valid),
        .o_ready (pr_ready),
        .i_acc   (acc),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_coef  (coef)
    );

endmodule
